// ===== src/dsi_pkg.sv =====
`default_nettype none

package dsi_pkg;

  localparam int unsigned DEF_VALUE_WIDTH = 32;
  localparam int unsigned IO_W            = 32;
  localparam int unsigned COEF_W          = 24;
  localparam int unsigned DT_W            = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned PC_W            = 7;

  localparam logic [1:0]        RESET_METHOD    = 2'd1;
  localparam logic [COEF_W-1:0] RESET_STIFFNESS = 24'd983040;
  localparam logic [COEF_W-1:0] RESET_DAMPING   = 24'd6554;

  localparam logic MODE_LOAD = 1'b1;

  typedef enum logic [1:0] {
    M_EULER  = 2'd0,
    M_RK4    = 2'd1,
    M_VERLET = 2'd2
  } method_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METHOD    = 2'd0,
    CFG_STIFFNESS = 2'd1,
    CFG_DAMPING   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_NEG    = 4'd2,
    OP_MULK   = 4'd3,
    OP_MULB   = 4'd4,
    OP_MULDT  = 4'd5,
    OP_MULDTH = 4'd6,
    OP_DIV6   = 4'd7,
    OP_END    = 4'd8
  } op_e;

  // Scratch registers live in a small memory; X, V and ZERO are not stored there.
  typedef enum logic [3:0] {
    R_T1   = 4'd0,
    R_T2   = 4'd1,
    R_XS   = 4'd2,
    R_ADV  = 4'd3,
    R_BDX  = 4'd4,
    R_BDV  = 4'd5,
    R_CDX  = 4'd6,
    R_CDV  = 4'd7,
    R_DDX  = 4'd8,
    R_DDV  = 4'd9,
    R_X    = 4'd10,
    R_V    = 4'd11,
    R_ZERO = 4'd12
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e dst;
    src_e sa;
    src_e sb;
  } instr_t;

  typedef struct packed {
    logic start;
    op_e  op;
  } dsi_req_t;

  localparam logic [PC_W-1:0] PC_EULER  = 7'd0;
  localparam logic [PC_W-1:0] PC_RK4    = 7'd9;
  localparam logic [PC_W-1:0] PC_VERLET = 7'd52;

  function automatic instr_t mk(op_e op, src_e dst, src_e sa, src_e sb);
    instr_t i;
    i.op  = op;
    i.dst = dst;
    i.sa  = sa;
    i.sb  = sb;
    return i;
  endfunction

  // Microcode for one vector component; the sequencer runs it once per axis.
  function automatic instr_t ucode(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      // Semi-implicit Euler
      7'd0:  i = mk(OP_MULK,   R_T1,  R_X,   R_ZERO);
      7'd1:  i = mk(OP_NEG,    R_T1,  R_T1,  R_ZERO);
      7'd2:  i = mk(OP_MULB,   R_T2,  R_V,   R_ZERO);
      7'd3:  i = mk(OP_SUB,    R_T1,  R_T1,  R_T2);
      7'd4:  i = mk(OP_MULDT,  R_T1,  R_T1,  R_ZERO);
      7'd5:  i = mk(OP_ADD,    R_V,   R_V,   R_T1);
      7'd6:  i = mk(OP_MULDT,  R_T1,  R_V,   R_ZERO);
      7'd7:  i = mk(OP_ADD,    R_X,   R_X,   R_T1);
      7'd8:  i = mk(OP_END,    R_ZERO, R_ZERO, R_ZERO);
      // RK4, first slope
      7'd9:  i = mk(OP_MULK,   R_T1,  R_X,   R_ZERO);
      7'd10: i = mk(OP_NEG,    R_T1,  R_T1,  R_ZERO);
      7'd11: i = mk(OP_MULB,   R_T2,  R_V,   R_ZERO);
      7'd12: i = mk(OP_SUB,    R_ADV, R_T1,  R_T2);
      // second slope
      7'd13: i = mk(OP_MULDTH, R_T1,  R_V,   R_ZERO);
      7'd14: i = mk(OP_ADD,    R_XS,  R_X,   R_T1);
      7'd15: i = mk(OP_MULDTH, R_T1,  R_ADV, R_ZERO);
      7'd16: i = mk(OP_ADD,    R_BDX, R_V,   R_T1);
      7'd17: i = mk(OP_MULK,   R_T1,  R_XS,  R_ZERO);
      7'd18: i = mk(OP_NEG,    R_T1,  R_T1,  R_ZERO);
      7'd19: i = mk(OP_MULB,   R_T2,  R_BDX, R_ZERO);
      7'd20: i = mk(OP_SUB,    R_BDV, R_T1,  R_T2);
      // third slope
      7'd21: i = mk(OP_MULDTH, R_T1,  R_BDX, R_ZERO);
      7'd22: i = mk(OP_ADD,    R_XS,  R_X,   R_T1);
      7'd23: i = mk(OP_MULDTH, R_T1,  R_BDV, R_ZERO);
      7'd24: i = mk(OP_ADD,    R_CDX, R_V,   R_T1);
      7'd25: i = mk(OP_MULK,   R_T1,  R_XS,  R_ZERO);
      7'd26: i = mk(OP_NEG,    R_T1,  R_T1,  R_ZERO);
      7'd27: i = mk(OP_MULB,   R_T2,  R_CDX, R_ZERO);
      7'd28: i = mk(OP_SUB,    R_CDV, R_T1,  R_T2);
      // fourth slope
      7'd29: i = mk(OP_MULDT,  R_T1,  R_CDX, R_ZERO);
      7'd30: i = mk(OP_ADD,    R_XS,  R_X,   R_T1);
      7'd31: i = mk(OP_MULDT,  R_T1,  R_CDV, R_ZERO);
      7'd32: i = mk(OP_ADD,    R_DDX, R_V,   R_T1);
      7'd33: i = mk(OP_MULK,   R_T1,  R_XS,  R_ZERO);
      7'd34: i = mk(OP_NEG,    R_T1,  R_T1,  R_ZERO);
      7'd35: i = mk(OP_MULB,   R_T2,  R_DDX, R_ZERO);
      7'd36: i = mk(OP_SUB,    R_DDV, R_T1,  R_T2);
      // position update; the first position slope is the old velocity
      7'd37: i = mk(OP_ADD,    R_T1,  R_BDX, R_CDX);
      7'd38: i = mk(OP_ADD,    R_T1,  R_T1,  R_T1);
      7'd39: i = mk(OP_ADD,    R_T1,  R_V,   R_T1);
      7'd40: i = mk(OP_ADD,    R_T1,  R_T1,  R_DDX);
      7'd41: i = mk(OP_MULDT,  R_T1,  R_T1,  R_ZERO);
      7'd42: i = mk(OP_DIV6,   R_T1,  R_T1,  R_ZERO);
      7'd43: i = mk(OP_ADD,    R_X,   R_X,   R_T1);
      // velocity update
      7'd44: i = mk(OP_ADD,    R_T1,  R_BDV, R_CDV);
      7'd45: i = mk(OP_ADD,    R_T1,  R_T1,  R_T1);
      7'd46: i = mk(OP_ADD,    R_T1,  R_ADV, R_T1);
      7'd47: i = mk(OP_ADD,    R_T1,  R_T1,  R_DDV);
      7'd48: i = mk(OP_MULDT,  R_T1,  R_T1,  R_ZERO);
      7'd49: i = mk(OP_DIV6,   R_T1,  R_T1,  R_ZERO);
      7'd50: i = mk(OP_ADD,    R_V,   R_V,   R_T1);
      7'd51: i = mk(OP_END,    R_ZERO, R_ZERO, R_ZERO);
      // Velocity Verlet
      7'd52: i = mk(OP_MULK,   R_T1,  R_X,   R_ZERO);
      7'd53: i = mk(OP_NEG,    R_T1,  R_T1,  R_ZERO);
      7'd54: i = mk(OP_MULB,   R_T2,  R_V,   R_ZERO);
      7'd55: i = mk(OP_SUB,    R_ADV, R_T1,  R_T2);
      7'd56: i = mk(OP_MULDT,  R_T1,  R_V,   R_ZERO);
      7'd57: i = mk(OP_ADD,    R_XS,  R_X,   R_T1);
      7'd58: i = mk(OP_MULDT,  R_T1,  R_ADV, R_ZERO);
      7'd59: i = mk(OP_MULDTH, R_T1,  R_T1,  R_ZERO);
      7'd60: i = mk(OP_ADD,    R_XS,  R_XS,  R_T1);
      7'd61: i = mk(OP_MULK,   R_T1,  R_XS,  R_ZERO);
      7'd62: i = mk(OP_NEG,    R_T1,  R_T1,  R_ZERO);
      7'd63: i = mk(OP_MULB,   R_T2,  R_V,   R_ZERO);
      7'd64: i = mk(OP_SUB,    R_T1,  R_T1,  R_T2);
      7'd65: i = mk(OP_ADD,    R_T1,  R_T1,  R_ADV);
      7'd66: i = mk(OP_MULDTH, R_T1,  R_T1,  R_ZERO);
      7'd67: i = mk(OP_ADD,    R_V,   R_V,   R_T1);
      7'd68: i = mk(OP_ADD,    R_X,   R_XS,  R_ZERO);
      default: i = mk(OP_END,  R_ZERO, R_ZERO, R_ZERO);
    endcase
    return i;
  endfunction

endpackage

`default_nettype wire

// ===== src/dsi_alu.sv =====
`default_nettype none

module dsi_alu import dsi_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dsi_req_t               req_i,
  input  wire logic [VALUE_WIDTH-1:0] opa_i,
  input  wire logic [VALUE_WIDTH-1:0] opb_i,
  input  wire logic [COEF_W-1:0]      stiffness_i,
  input  wire logic [COEF_W-1:0]      damping_i,
  input  wire logic [DT_W-1:0]        step_time_i,
  output logic                        done_o,
  output logic [VALUE_WIDTH-1:0]      res_o
);

  localparam int unsigned W         = VALUE_WIDTH;
  localparam int unsigned DIG       = 8;
  localparam int unsigned AW        = W + COEF_W;
  localparam int unsigned MUL_STEPS = COEF_W / DIG;
  localparam int unsigned NDIG      = (W + DIG - 1) / DIG;
  localparam int unsigned QW        = NDIG * DIG;
  localparam int unsigned CW        = $clog2(NDIG + MUL_STEPS);
  localparam int unsigned SH_FULL   = 16;
  localparam int unsigned SH_HALF   = 17;

  localparam logic [W-1:0] V_MAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] V_MIN   = ~V_MAX;
  localparam logic [AW:0]  LIM_E   = (AW+1)'(V_MAX);
  localparam logic [AW:0]  RND_F   = (AW+1)'(1) << (SH_FULL - 1);
  localparam logic [AW:0]  RND_H   = (AW+1)'(1) << (SH_HALF - 1);
  localparam logic [3:0]   DIVISOR = 4'd6;
  localparam logic [W-1:0] DIV_BIAS = W'(3);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } alu_state_e;

  alu_state_e        state_q;
  logic [CW-1:0]     cnt_q;
  logic              done_q;
  logic [W-1:0]      mag_q;
  logic              neg_q;
  logic              half_q;
  logic              div_q;
  logic [COEF_W-1:0] coef_q;
  logic [AW-1:0]     acc_q;
  logic [QW-1:0]     num_q;
  logic [QW-1:0]     quo_q;
  logic [2:0]        rem_q;
  logic [W-1:0]      res_q;

  logic [W-1:0]      abs_a;
  logic [W-1:0]      op_res;
  logic [COEF_W-1:0] coef_sel;
  logic [W+DIG-1:0]  part;
  logic [AW-1:0]     acc_d;
  logic [AW:0]       rnd;
  logic [AW:0]       rsh;
  logic [W-1:0]      mul_res;
  logic [W-1:0]      div_res;
  logic [QW-1:0]     num_d;
  logic [QW-1:0]     quo_d;
  logic [2:0]        rem_d;

  function automatic logic [W-1:0] sat_wide(logic [W:0] s);
    if (s[W] != s[W-1]) begin
      return s[W] ? V_MIN : V_MAX;
    end
    return s[W-1:0];
  endfunction

  assign abs_a = opa_i[W-1] ? (~opa_i + W'(1)) : opa_i;

  always_comb begin
    case (req_i.op)
      OP_ADD:  op_res = sat_wide({opa_i[W-1], opa_i} + {opb_i[W-1], opb_i});
      OP_SUB:  op_res = sat_wide({opa_i[W-1], opa_i} - {opb_i[W-1], opb_i});
      OP_NEG:  op_res = (opa_i == V_MIN) ? V_MAX : (~opa_i + W'(1));
      default: op_res = opa_i;
    endcase
    case (req_i.op)
      OP_MULK: coef_sel = stiffness_i;
      OP_MULB: coef_sel = damping_i;
      default: coef_sel = COEF_W'(step_time_i);
    endcase
  end

  // One byte of the coefficient per cycle, most significant byte first.
  assign part  = (W+DIG)'(mag_q) * (W+DIG)'(coef_q[COEF_W-1 -: DIG]);
  assign acc_d = (acc_q << DIG) + AW'(part);

  always_comb begin
    rnd = {1'b0, acc_q} + (half_q ? RND_H : RND_F);
    rsh = half_q ? (rnd >> SH_HALF) : (rnd >> SH_FULL);
    if (!neg_q) begin
      mul_res = (rsh > LIM_E) ? V_MAX : rsh[W-1:0];
    end else if (rsh > LIM_E + (AW+1)'(1)) begin
      mul_res = V_MIN;
    end else begin
      mul_res = ~rsh[W-1:0] + W'(1);
    end
  end

  // Restoring division by six, eight quotient bits per cycle.
  always_comb begin
    logic [3:0] t;
    num_d = num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < DIG; i++) begin
      t     = {rem_d, num_d[QW-1]};
      num_d = num_d << 1;
      if (t >= DIVISOR) begin
        rem_d = 3'(t - DIVISOR);
        quo_d = {quo_d[QW-2:0], 1'b1};
      end else begin
        rem_d = t[2:0];
        quo_d = {quo_d[QW-2:0], 1'b0};
      end
    end
  end

  assign div_res = neg_q ? (~quo_q[W-1:0] + W'(1)) : quo_q[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            cnt_q <= '0;
            case (req_i.op) inside
              OP_MULK, OP_MULB, OP_MULDT, OP_MULDTH: state_q <= A_MUL;
              OP_DIV6: state_q <= A_DIV;
              default: done_q <= 1'b1;
            endcase
          end
        end
        A_MUL: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(MUL_STEPS - 1)) begin
            state_q <= A_FIN;
          end
        end
        A_DIV: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(NDIG - 1)) begin
            state_q <= A_FIN;
          end
        end
        A_FIN: begin
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          mag_q  <= abs_a;
          neg_q  <= opa_i[W-1];
          half_q <= (req_i.op == OP_MULDTH);
          div_q  <= (req_i.op == OP_DIV6);
          coef_q <= coef_sel;
          acc_q  <= '0;
          num_q  <= QW'(abs_a + DIV_BIAS);
          quo_q  <= '0;
          rem_q  <= '0;
          res_q  <= op_res;
        end
      end
      A_MUL: begin
        acc_q  <= acc_d;
        coef_q <= coef_q << DIG;
      end
      A_DIV: begin
        num_q <= num_d;
        quo_q <= quo_d;
        rem_q <= rem_d;
      end
      A_FIN: res_q <= div_q ? div_res : mul_res;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== src/damped_spring_integrator_core.sv =====
`default_nettype none

// Damped 2D spring integrator. Each input word either loads a new position and
// velocity (saturated to VALUE_WIDTH bits) or advances the state by step_time
// with the method selected by the method register: semi-implicit Euler, RK4 or
// velocity Verlet; method code 3 returns the state unchanged. Every input word
// yields one output word holding the state after it, saturated to 32 bits.
// All arithmetic runs on one shared unit driven by a microcode sequencer, one
// axis after the other. Each microcode step is fetched, issued and waited on;
// an add, subtract or negate is computed combinationally and registered in the
// unit, a coefficient multiply takes one 8-bit coefficient slice per cycle and
// the divide by six works through the dividend byte by byte. The input is
// stalled while a word is being processed; a finished word waits in the output
// register.
module damped_spring_integrator_core import dsi_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [COEF_W-1:0]      cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   mode_i,
  input  wire logic [DT_W-1:0]        step_time_i,
  input  wire logic signed [IO_W-1:0] load_pos_x_i,
  input  wire logic signed [IO_W-1:0] load_pos_y_i,
  input  wire logic signed [IO_W-1:0] load_vel_x_i,
  input  wire logic signed [IO_W-1:0] load_vel_y_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [IO_W-1:0]      pos_x_o,
  output logic signed [IO_W-1:0]      pos_y_o,
  output logic signed [IO_W-1:0]      vel_x_o,
  output logic signed [IO_W-1:0]      vel_y_o
);

  localparam int unsigned W      = VALUE_WIDTH;
  localparam int unsigned XW     = (W > IO_W) ? W : IO_W;
  localparam int unsigned MEM_AW = $bits(src_e) + 1;
  localparam int unsigned MEM_D  = 1 << MEM_AW;

  localparam logic signed [XW-1:0] V_MAX = XW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [XW-1:0] V_MIN = ~V_MAX;
  localparam logic signed [XW-1:0] O_MAX = XW'({1'b0, {(IO_W-1){1'b1}}});
  localparam logic signed [XW-1:0] O_MIN = ~O_MAX;

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_FETCH = 5'b00010,
    T_ISSUE = 5'b00100,
    T_WAIT  = 5'b01000,
    T_OUT   = 5'b10000
  } seq_state_e;

  seq_state_e        state_q;
  logic [1:0]        method_q;
  logic [COEF_W-1:0] stiff_q;
  logic [COEF_W-1:0] damp_q;
  logic [DT_W-1:0]   dt_q;
  logic [PC_W-1:0]   pc_q;
  logic              comp_q;
  logic [W-1:0]      pos_q [0:1];
  logic [W-1:0]      vel_q [0:1];
  logic              out_valid_q;
  logic [IO_W-1:0]   out_pos_x_q;
  logic [IO_W-1:0]   out_pos_y_q;
  logic [IO_W-1:0]   out_vel_x_q;
  logic [IO_W-1:0]   out_vel_y_q;

  logic [W-1:0]      mem_q [0:MEM_D-1];
  logic [W-1:0]      rda_q;
  logic [W-1:0]      rdb_q;

  instr_t            ins;
  logic              in_acc;
  logic              alu_done;
  logic [W-1:0]      alu_res;
  logic [W-1:0]      opa;
  logic [W-1:0]      opb;
  logic              mem_we;
  dsi_req_t          alu_req;

  function automatic logic [W-1:0] to_val(logic signed [IO_W-1:0] a);
    logic signed [XW-1:0] e;
    e = XW'(a);
    if (e > V_MAX) begin
      e = V_MAX;
    end else if (e < V_MIN) begin
      e = V_MIN;
    end
    return e[W-1:0];
  endfunction

  function automatic logic [IO_W-1:0] to_io(logic [W-1:0] a);
    logic signed [XW-1:0] e;
    e = XW'($signed(a));
    if (e > O_MAX) begin
      e = O_MAX;
    end else if (e < O_MIN) begin
      e = O_MIN;
    end
    return e[IO_W-1:0];
  endfunction

  function automatic logic [PC_W-1:0] start_pc(logic [1:0] m);
    case (m)
      M_EULER:  return PC_EULER;
      M_VERLET: return PC_VERLET;
      default:  return PC_RK4;
    endcase
  endfunction

  function automatic logic [W-1:0] pick(src_e s, logic [W-1:0] rd, logic [W-1:0] x,
                                        logic [W-1:0] v);
    case (s)
      R_X:     return x;
      R_V:     return v;
      R_ZERO:  return '0;
      default: return rd;
    endcase
  endfunction

  assign ins        = ucode(pc_q);
  assign in_stall_o = (state_q != T_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign opa        = pick(ins.sa, rda_q, pos_q[comp_q], vel_q[comp_q]);
  assign opb        = pick(ins.sb, rdb_q, pos_q[comp_q], vel_q[comp_q]);
  assign mem_we     = (state_q == T_WAIT) && alu_done &&
                      (ins.dst != R_X) && (ins.dst != R_V) && (ins.dst != R_ZERO);

  assign alu_req.start = (state_q == T_ISSUE);
  assign alu_req.op    = ins.op;

  dsi_alu #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_alu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (alu_req),
    .opa_i       (opa),
    .opb_i       (opb),
    .stiffness_i (stiff_q),
    .damping_i   (damp_q),
    .step_time_i (dt_q),
    .done_o      (alu_done),
    .res_o       (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= RESET_METHOD;
      stiff_q  <= RESET_STIFFNESS;
      damp_q   <= RESET_DAMPING;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_METHOD:    method_q <= cfg_data_i[1:0];
        CFG_STIFFNESS: stiff_q  <= cfg_data_i;
        CFG_DAMPING:   damp_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      pc_q        <= '0;
      comp_q      <= 1'b0;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      vel_q[0]    <= '0;
      vel_q[1]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (in_acc) begin
            comp_q <= 1'b0;
            pc_q   <= start_pc(method_q);
            if (mode_i == MODE_LOAD) begin
              pos_q[0] <= to_val(load_pos_x_i);
              pos_q[1] <= to_val(load_pos_y_i);
              vel_q[0] <= to_val(load_vel_x_i);
              vel_q[1] <= to_val(load_vel_y_i);
              state_q  <= T_OUT;
            end else begin
              case (method_q) inside
                M_EULER, M_RK4, M_VERLET: state_q <= T_FETCH;
                default: state_q <= T_OUT;
              endcase
            end
          end
        end
        T_FETCH: begin
          if (ins.op == OP_END) begin
            if (!comp_q) begin
              comp_q <= 1'b1;
              pc_q   <= start_pc(method_q);
            end else begin
              state_q <= T_OUT;
            end
          end else begin
            state_q <= T_ISSUE;
          end
        end
        T_ISSUE: state_q <= T_WAIT;
        T_WAIT: begin
          if (alu_done) begin
            if (ins.dst == R_X) begin
              pos_q[comp_q] <= alu_res;
            end else if (ins.dst == R_V) begin
              vel_q[comp_q] <= alu_res;
            end
            pc_q    <= pc_q + PC_W'(1);
            state_q <= T_FETCH;
          end
        end
        T_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            state_q     <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q <= step_time_i;
    end
    if ((state_q == T_OUT) && !out_valid_q) begin
      out_pos_x_q <= to_io(pos_q[0]);
      out_pos_y_q <= to_io(pos_q[1]);
      out_vel_x_q <= to_io(vel_q[0]);
      out_vel_y_q <= to_io(vel_q[1]);
    end
  end

  // Scratch memory, one bank per axis, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[{comp_q, ins.dst}] <= alu_res;
    end
    rda_q <= mem_q[{comp_q, ins.sa}];
    rdb_q <= mem_q[{comp_q, ins.sb}];
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_pos_x_q;
  assign pos_y_o     = out_pos_y_q;
  assign vel_x_o     = out_vel_x_q;
  assign vel_y_o     = out_vel_y_q;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;
  import dsi_pkg::*;

  localparam int NUM_RANDOM = 800;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  typedef struct {
    logic        mode;
    logic [15:0] dt;
    logic [31:0] px, py, vx, vy;
  } word_t;

  typedef struct packed {
    logic [31:0] px, py, vx, vy;
  } state_t;

  // Directed rows: a state is typed in where it is obvious, otherwise predicted.
  typedef struct {
    word_t  w;
    bit     typed;
    state_t st;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [COEF_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic mode_i = 1'b0;
  logic [DT_W-1:0] step_time_i = '0;
  logic signed [IO_W-1:0] load_pos_x_i = '0, load_pos_y_i = '0;
  logic signed [IO_W-1:0] load_vel_x_i = '0, load_vel_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [IO_W-1:0] pos_x_o, pos_y_o, vel_x_o, vel_y_o;

  always #4 clk_i = ~clk_i;

  damped_spring_integrator_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .mode_i, .step_time_i,
    .load_pos_x_i, .load_pos_y_i, .load_vel_x_i, .load_vel_y_i,
    .out_valid_o, .out_stall_i, .pos_x_o, .pos_y_o, .vel_x_o, .vel_y_o
  );

  logic [1:0]  p_method = RESET_METHOD;
  logic [23:0] p_k = RESET_STIFFNESS;
  logic [23:0] p_b = RESET_DAMPING;
  longint      s_px, s_py, s_vx, s_vy;

  state_t expected_states[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     long_hold = 1'b0;
  bit     rx_quiet = 1'b0;

  function automatic longint sat(longint a);
    if (a > VMAX) return VMAX;
    if (a < VMIN) return VMIN;
    return a;
  endfunction

  function automatic longint neg_sat(longint a);
    return sat(-a);
  endfunction

  // Rounded scaled product, ties away from zero; magnitudes fit in 64 bits easily.
  function automatic longint scale(longint a, logic [23:0] c, int sh);
    longint unsigned m, r;
    m = a < 0 ? -a : a;
    r = (m * c + (64'd1 << (sh - 1))) >> sh;
    if (r > 64'd2147483648) r = 64'd2147483648;
    return a < 0 ? sat(-longint'(r)) : sat(longint'(r));
  endfunction

  function automatic longint div_by6(longint a);
    longint unsigned m;
    m = a < 0 ? -a : a;
    m = (m + 3) / 6;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint spring_accel(longint x, longint v);
    return sat(neg_sat(scale(x, p_k, 16)) - scale(v, p_b, 16));
  endfunction

  function automatic longint rk_sum(longint a, longint b, longint c, longint d,
                                    logic [15:0] dt);
    longint t, s;
    t = sat(b + c);
    s = sat(sat(a + sat(t + t)) + d);
    return div_by6(scale(s, dt, 16));
  endfunction

  // One axis of a time step; updates x and v in place.
  task automatic advance_axis(inout longint x, inout longint v, input logic [15:0] dt);
    longint a0, a1, xs, np, bx, bv, cx, cv, dx, dv;
    case (p_method)
      M_EULER: begin
        v = sat(v + scale(spring_accel(x, v), dt, 16));
        x = sat(x + scale(v, dt, 16));
      end
      M_RK4: begin
        a0 = spring_accel(x, v);
        xs = sat(x + scale(v, dt, 17));
        bx = sat(v + scale(a0, dt, 17));
        bv = spring_accel(xs, bx);
        xs = sat(x + scale(bx, dt, 17));
        cx = sat(v + scale(bv, dt, 17));
        cv = spring_accel(xs, cx);
        xs = sat(x + scale(cx, dt, 16));
        dx = sat(v + scale(cv, dt, 16));
        dv = spring_accel(xs, dx);
        np = sat(x + rk_sum(v, bx, cx, dx, dt));
        v = sat(v + rk_sum(a0, bv, cv, dv, dt));
        x = np;
      end
      M_VERLET: begin
        a0 = spring_accel(x, v);
        np = sat(x + scale(v, dt, 16));
        np = sat(np + scale(scale(a0, dt, 16), dt, 17));
        a1 = spring_accel(np, v);
        v = sat(v + scale(sat(a1 + a0), dt, 17));
        x = np;
      end
      default: ;
    endcase
  endtask

  function automatic state_t current_state();
    state_t s;
    s.px = s_px[31:0]; s.py = s_py[31:0];
    s.vx = s_vx[31:0]; s.vy = s_vy[31:0];
    return s;
  endfunction

  task automatic predict_word(input word_t w);
    if (w.mode == MODE_LOAD) begin
      s_px = longint'($signed(w.px)); s_py = longint'($signed(w.py));
      s_vx = longint'($signed(w.vx)); s_vy = longint'($signed(w.vy));
    end else begin
      advance_axis(s_px, s_vx, w.dt);
      advance_axis(s_py, s_vy, w.dt);
    end
    expected_states.push_back(current_state());
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // Typed-in states are compared against the predictor in the Euler pass, so a bad row shows.
  task automatic send_word(input word_t w);
    mode_i <= w.mode; step_time_i <= w.dt;
    load_pos_x_i <= w.px; load_pos_y_i <= w.py;
    load_vel_x_i <= w.vx; load_vel_y_i <= w.vy;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(w);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_METHOD: p_method = val[1:0];
      CFG_STIFFNESS: p_k = val;
      default: p_b = val;
    endcase
  endtask

  task automatic drain();
    while (expected_states.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endcase
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w.mode = ($urandom_range(0, 7) == 0);
    w.dt = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2000));
    w.px = rand_value(); w.py = rand_value();
    w.vx = rand_value(); w.vy = rand_value();
    return w;
  endfunction

  function automatic word_t mk_word(logic m, logic [15:0] dt, logic [31:0] px,
                                    logic [31:0] py, logic [31:0] vx, logic [31:0] vy);
    word_t w;
    w.mode = m; w.dt = dt; w.px = px; w.py = py; w.vx = vx; w.vy = vy;
    return w;
  endfunction

  // Output side: random stalls, one long hold-off, and the scoreboard.
  always @(negedge clk_i) begin
    if (long_hold) out_stall_i <= 1'b1;
    else if (rx_quiet) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 19) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    state_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_states.size() == 0) begin
        $display("unexpected result word");
        errors++;
      end else begin
        want = expected_states.pop_front();
        if (pos_x_o !== want.px) report("pos_x", pos_x_o, want.px);
        if (pos_y_o !== want.py) report("pos_y", pos_y_o, want.py);
        if (vel_x_o !== want.vx) report("vel_x", vel_x_o, want.vx);
        if (vel_y_o !== want.vy) report("vel_y", vel_y_o, want.vy);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    state_t zero_st;
    logic [23:0] ks[4];
    logic [23:0] bs[4];
    int unsigned phase;
    zero_st = '{default: 32'h0};
    s_px = 0; s_py = 0; s_vx = 0; s_vy = 0;

    // Stepping from rest stays at rest.
    r.w = mk_word(1'b0, 16'hffff, 0, 0, 0, 0); r.typed = 1; r.st = zero_st; rows.push_back(r);
    r.w = mk_word(1'b1, 0, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    r.typed = 1;
    r.st = '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff};
    rows.push_back(r);
    r.typed = 0;
    r.w = mk_word(1'b0, 16'hffff, 0, 0, 0, 0); rows.push_back(r);
    r.w = mk_word(1'b0, 0, 0, 0, 0, 0); rows.push_back(r);
    r.w = mk_word(1'b1, 16'hffff, 32'h00010000, 32'hffff0000, 32'h0, 32'h00008000);
    rows.push_back(r);
    r.w = mk_word(1'b0, 16'd655, 0, 0, 0, 0); rows.push_back(r);
    r.w = mk_word(1'b0, 16'h8000, 0, 0, 0, 0); rows.push_back(r);
    r.w = mk_word(1'b0, 16'd1, 0, 0, 0, 0); rows.push_back(r);
    r.w = mk_word(1'b1, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    rows.push_back(r);
    r.w = mk_word(1'b0, 16'hffff, 0, 0, 0, 0); rows.push_back(r);
    r.w = mk_word(1'b0, 16'hffff, 0, 0, 0, 0); rows.push_back(r);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Each method, then the unused code, on the directed rows.
    for (int m = 0; m < 4; m++) begin
      if (m != RESET_METHOD || m != 0) write_reg(CFG_METHOD, 24'(m));
      foreach (rows[i]) begin
        if (rows[i].typed && m == 0 && i < 2) begin
          send_word(rows[i].w);
          if (expected_states[$] != rows[i].st) begin
            $display("directed row %0d disagrees with predictor", i);
            errors++;
          end
        end else begin
          send_word(rows[i].w);
        end
        sender_gap();
      end
      drain();
    end

    // Long receiver hold-off while words keep arriving.
    write_reg(CFG_METHOD, M_EULER);
    long_hold = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk_i);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_word(rand_word());
    join
    drain();

    ks = '{24'd0, 24'hffffff, RESET_STIFFNESS, 24'd65536};
    bs = '{24'd0, 24'hffffff, RESET_DAMPING, 24'd32768};
    for (phase = 0; phase < 16; phase++) begin
      if (phase < 4) begin
        write_reg(CFG_STIFFNESS, ks[phase]);
        write_reg(CFG_DAMPING, bs[phase]);
      end else begin
        write_reg(CFG_STIFFNESS, ($urandom_range(0, 4) == 0) ? 24'($urandom())
                                                            : 24'($urandom_range(0, 40 << 16)));
        write_reg(CFG_DAMPING, ($urandom_range(0, 4) == 0) ? 24'($urandom())
                                                          : 24'($urandom_range(0, 4 << 16)));
      end
      write_reg(CFG_METHOD, ($urandom_range(0, 7) == 0) ? 24'd3 : 24'($urandom_range(0, 2)));
      rx_quiet = (phase % 4 == 3);
      for (int i = 0; i < NUM_RANDOM / 16; i++) begin
        send_word(rand_word());
        if (phase % 4 != 3) sender_gap();
      end
      drain();
    end

    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
